@@ sv/cfah_pkg.sv @@
package cfah_pkg;

   localparam int MAX_PAYLOAD       = 8;
   localparam int HEADER_BYTES      = 6;
   localparam int BYTE_COUNT        = HEADER_BYTES + MAX_PAYLOAD;
   localparam int IDX_WIDTH         = $clog2(BYTE_COUNT);
   localparam int FOLD_STEPS        = 4;
   localparam int FOLD_WIDTH        = $clog2(FOLD_STEPS);
   localparam int ID_WIDTH          = 32;
   localparam int DLC_WIDTH         = 4;
   localparam int CHAR_WIDTH        = 8;
   localparam int SUM_WIDTH         = 32;
   localparam int CSR_INDEX_WIDTH   = 1;
   localparam int CSR_DATA_WIDTH    = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CHECKSUM_START  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LINE_TERMINATOR = 1'd1;

   localparam logic [SUM_WIDTH-1:0]  CHECKSUM_START_RESET  = 32'd42405;
   localparam logic [CHAR_WIDTH-1:0] LINE_TERMINATOR_RESET = 8'd10;

   typedef struct packed {
      logic [ID_WIDTH-1:0]                   can_id;
      logic [DLC_WIDTH-1:0]                  data_length;
      logic [MAX_PAYLOAD-1:0][CHAR_WIDTH-1:0] payload;
   } frame_type;

   typedef enum logic [2:0] {
      SEL_BYTE_HI,
      SEL_BYTE_LO,
      SEL_SUM_HI,
      SEL_SUM_LO,
      SEL_TERM
   } char_sel_type;

   typedef struct packed {
      logic         load;
      logic         put;
      char_sel_type sel;
      logic         fold;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic last_byte;
      logic fold_last;
   } status_type;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_BYTE_HI = 7'b0000010,
      ST_BYTE_LO = 7'b0000100,
      ST_FOLD    = 7'b0001000,
      ST_SUM_HI  = 7'b0010000,
      ST_SUM_LO  = 7'b0100000,
      ST_TERM    = 7'b1000000
   } state_type;

   function automatic logic [CHAR_WIDTH-1:0] hex_char(input logic [3:0] nibble);
      logic [CHAR_WIDTH-1:0] ch;
      if (nibble < 4'd10) begin
         ch = 8'h30 + {4'd0, nibble};
      end else begin
         ch = 8'h37 + {4'd0, nibble};
      end
      return ch;
   endfunction

endpackage

@@ sv/cfah_req_if.sv @@
interface cfah_req_if;
   logic                                             valid;
   logic                                             ready;
   logic [cfah_pkg::ID_WIDTH-1:0]                    can_id;
   logic [cfah_pkg::DLC_WIDTH-1:0]                   data_length;
   logic [7:0]                                       payload_0;
   logic [7:0]                                       payload_1;
   logic [7:0]                                       payload_2;
   logic [7:0]                                       payload_3;
   logic [7:0]                                       payload_4;
   logic [7:0]                                       payload_5;
   logic [7:0]                                       payload_6;
   logic [7:0]                                       payload_7;

   modport source (output valid, can_id, data_length, payload_0, payload_1, payload_2,
                   payload_3, payload_4, payload_5, payload_6, payload_7,
                   input ready);
   modport sink (input valid, can_id, data_length, payload_0, payload_1, payload_2,
                 payload_3, payload_4, payload_5, payload_6, payload_7,
                 output ready);
endinterface

@@ sv/cfah_rsp_if.sv @@
interface cfah_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [cfah_pkg::CHAR_WIDTH-1:0]   ascii_char;
   logic                              line_end;

   modport source (output valid, ascii_char, line_end, input ready);
   modport sink (input valid, ascii_char, line_end, output ready);
endinterface

@@ sv/cfah_ctrl.sv @@
module cfah_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  cfah_pkg::status_type   status,
   output cfah_pkg::cmd_type      cmd
);

   cfah_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfah_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == cfah_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.load = 1'b0;
      cmd.put  = 1'b0;
      cmd.sel  = cfah_pkg::SEL_BYTE_HI;
      cmd.fold = 1'b0;
      unique case (state_ff)
         cfah_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = cfah_pkg::ST_BYTE_HI;
            end
         end
         cfah_pkg::ST_BYTE_HI: begin
            cmd.sel = cfah_pkg::SEL_BYTE_HI;
            if (status.out_free) begin
               cmd.put  = 1'b1;
               state_in = cfah_pkg::ST_BYTE_LO;
            end
         end
         cfah_pkg::ST_BYTE_LO: begin
            cmd.sel = cfah_pkg::SEL_BYTE_LO;
            if (status.out_free) begin
               cmd.put  = 1'b1;
               state_in = status.last_byte ? cfah_pkg::ST_FOLD : cfah_pkg::ST_BYTE_HI;
            end
         end
         cfah_pkg::ST_FOLD: begin
            cmd.fold = 1'b1;
            if (status.fold_last) begin
               state_in = cfah_pkg::ST_SUM_HI;
            end
         end
         cfah_pkg::ST_SUM_HI: begin
            cmd.sel = cfah_pkg::SEL_SUM_HI;
            if (status.out_free) begin
               cmd.put  = 1'b1;
               state_in = cfah_pkg::ST_SUM_LO;
            end
         end
         cfah_pkg::ST_SUM_LO: begin
            cmd.sel = cfah_pkg::SEL_SUM_LO;
            if (status.out_free) begin
               cmd.put  = 1'b1;
               state_in = cfah_pkg::ST_TERM;
            end
         end
         cfah_pkg::ST_TERM: begin
            cmd.sel = cfah_pkg::SEL_TERM;
            if (status.out_free) begin
               cmd.put  = 1'b1;
               state_in = cfah_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cfah_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ sv/cfah_dp.sv @@
module cfah_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [cfah_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [cfah_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data,
   input  cfah_pkg::frame_type                    frame,
   input  cfah_pkg::cmd_type                      cmd,
   output cfah_pkg::status_type                   status,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output logic [cfah_pkg::CHAR_WIDTH-1:0]        rsp_ascii_char,
   output logic                                   rsp_line_end
);

   localparam int IW = cfah_pkg::IDX_WIDTH;
   localparam int CW = cfah_pkg::CHAR_WIDTH;

   logic [cfah_pkg::SUM_WIDTH-1:0]  csum_start_ff;
   logic [CW-1:0]                   term_ff;
   logic [CW-1:0]                   seq_ff;
   logic [CW-1:0]                   bytes_ff [cfah_pkg::BYTE_COUNT];
   logic [IW-1:0]                   last_idx_ff, last_idx_in;
   logic [IW-1:0]                   idx_ff;
   logic [cfah_pkg::SUM_WIDTH-1:0]  sum_ff, fold_in;
   logic [cfah_pkg::FOLD_WIDTH-1:0] fold_cnt_ff;
   logic [CW-1:0]                   char_ff, char_in;
   logic                            end_ff;
   logic                            valid_ff;
   logic [CW-1:0]                   cur_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         csum_start_ff <= cfah_pkg::CHECKSUM_START_RESET;
         term_ff       <= cfah_pkg::LINE_TERMINATOR_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == cfah_pkg::REG_CHECKSUM_START) begin
            csum_start_ff <= csr_write_data;
         end
         if (csr_index == cfah_pkg::REG_LINE_TERMINATOR) begin
            term_ff <= csr_write_data[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= '0;
      end else if (cmd.load) begin
         seq_ff <= seq_ff + 8'd1;
      end
   end

   // A long DLC is still sent as is, but only the full payload follows it.
   always_comb begin
      if (frame.data_length > cfah_pkg::DLC_WIDTH'(cfah_pkg::MAX_PAYLOAD)) begin
         last_idx_in = IW'(cfah_pkg::BYTE_COUNT - 1);
      end else begin
         last_idx_in = IW'(cfah_pkg::HEADER_BYTES - 1) + IW'(frame.data_length);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bytes_ff[0] <= seq_ff;
         bytes_ff[1] <= frame.can_id[7:0];
         bytes_ff[2] <= frame.can_id[15:8];
         bytes_ff[3] <= frame.can_id[23:16];
         bytes_ff[4] <= frame.can_id[31:24];
         bytes_ff[5] <= {4'd0, frame.data_length};
         for (int i = 0; i < cfah_pkg::MAX_PAYLOAD; i++) begin
            bytes_ff[cfah_pkg::HEADER_BYTES + i] <= frame.payload[i];
         end
      end
   end

   assign cur_byte = bytes_ff[idx_ff];

   // Two folds by 16 bits, then two by 8 bits.
   always_comb begin
      if (fold_cnt_ff[cfah_pkg::FOLD_WIDTH-1]) begin
         fold_in = sum_ff + (sum_ff >> 8);
      end else begin
         fold_in = sum_ff + (sum_ff >> 16);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         last_idx_ff <= last_idx_in;
         idx_ff      <= '0;
         sum_ff      <= csum_start_ff;
         fold_cnt_ff <= '0;
      end else begin
         if (cmd.put && cmd.sel == cfah_pkg::SEL_BYTE_HI) begin
            sum_ff <= sum_ff + {24'd0, cur_byte};
         end
         if (cmd.put && cmd.sel == cfah_pkg::SEL_BYTE_LO) begin
            idx_ff <= idx_ff + IW'(1);
         end
         if (cmd.fold) begin
            sum_ff      <= fold_in;
            fold_cnt_ff <= fold_cnt_ff + cfah_pkg::FOLD_WIDTH'(1);
         end
      end
   end

   always_comb begin
      unique case (cmd.sel)
         cfah_pkg::SEL_BYTE_HI: char_in = cfah_pkg::hex_char(cur_byte[7:4]);
         cfah_pkg::SEL_BYTE_LO: char_in = cfah_pkg::hex_char(cur_byte[3:0]);
         cfah_pkg::SEL_SUM_HI:  char_in = cfah_pkg::hex_char(sum_ff[7:4]);
         cfah_pkg::SEL_SUM_LO:  char_in = cfah_pkg::hex_char(sum_ff[3:0]);
         cfah_pkg::SEL_TERM:    char_in = term_ff;
         default:               char_in = term_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.put) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.put) begin
         char_ff <= char_in;
         end_ff  <= (cmd.sel == cfah_pkg::SEL_TERM);
      end
   end

   assign status.out_free  = !valid_ff || rsp_ready;
   assign status.last_byte = (idx_ff == last_idx_ff);
   assign status.fold_last = (fold_cnt_ff == cfah_pkg::FOLD_WIDTH'(cfah_pkg::FOLD_STEPS - 1));

   assign rsp_valid      = valid_ff;
   assign rsp_ascii_char = char_ff;
   assign rsp_line_end   = end_ff;

endmodule

@@ sv/can_frame_to_ascii_hex_line.sv @@
// Channel       Dir   Payload
// req_channel   in    can_id[31:0], data_length[3:0], payload_0..payload_7[7:0]
// rsp_channel   out   ascii_char[7:0], line_end
// csr_*         in    write enable, index (0 checksum_start, 1 line_terminator), data[31:0]
//
// A frame with n = min(data_length, 8) payload bytes yields 15 + 2n characters. The
// block accepts the frame, puts out the header and payload characters, folds the
// checksum four times, then puts out the checksum characters and the terminator.
// One frame is worked at a time, under the sequencer in the controller.
// Reset is synchronous; it clears the sequence count and restores both registers.
// A stall on the result side holds the sequencer; a new frame is taken while the
// terminator item still waits in the output register.
module can_frame_to_ascii_hex_line (
   input  logic                                   clock,
   input  logic                                   reset,
   cfah_req_if.sink                               req_channel,
   cfah_rsp_if.source                             rsp_channel,
   input  logic                                   csr_write_enable,
   input  logic [cfah_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [cfah_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   cfah_pkg::cmd_type    cmd;
   cfah_pkg::status_type status;
   cfah_pkg::frame_type  frame;

   assign frame.can_id      = req_channel.can_id;
   assign frame.data_length = req_channel.data_length;
   assign frame.payload[0]  = req_channel.payload_0;
   assign frame.payload[1]  = req_channel.payload_1;
   assign frame.payload[2]  = req_channel.payload_2;
   assign frame.payload[3]  = req_channel.payload_3;
   assign frame.payload[4]  = req_channel.payload_4;
   assign frame.payload[5]  = req_channel.payload_5;
   assign frame.payload[6]  = req_channel.payload_6;
   assign frame.payload[7]  = req_channel.payload_7;

   cfah_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_channel.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cfah_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .frame            (frame),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_channel.ready),
      .rsp_valid        (rsp_channel.valid),
      .rsp_ascii_char   (rsp_channel.ascii_char),
      .rsp_line_end     (rsp_channel.line_end)
   );

endmodule

@@ tb/tb_can_frame_to_ascii_hex_line.sv @@
module tb_can_frame_to_ascii_hex_line;
   timeunit 1ns;
   timeprecision 1ps;

   import cfah_pkg::*;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int REPORT_LIMIT   = 10;
   localparam int PHASE_FRAMES   = 50;

   typedef struct {
      logic [CHAR_WIDTH-1:0] ascii_char;
      logic                  line_end;
   } line_char_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   cfah_req_if req_if ();
   cfah_rsp_if rsp_if ();

   can_frame_to_ascii_hex_line dut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_if),
      .rsp_channel      (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Mirror of the block's registers and line counter.
   logic [SUM_WIDTH-1:0]  mirror_checksum_start;
   logic [CHAR_WIDTH-1:0] mirror_terminator;
   logic [7:0]            mirror_sequence;

   frame_type     frames_pending[$];
   frame_type     driven_frame;
   frame_type     staged_frame;
   line_char_type expected_chars[$];

   int send_idle_pct;
   int recv_stall_pct;
   int error_count;
   int cycle_count;

   function automatic logic [CHAR_WIDTH-1:0] hex_ascii(input logic [3:0] nibble);
      return (nibble < 4'd10) ? "0" + 8'(nibble) : "A" + 8'(nibble - 4'd10);
   endfunction

   function automatic void push_char(input logic [CHAR_WIDTH-1:0] ch, input logic last);
      line_char_type c;
      c.ascii_char = ch;
      c.line_end   = last;
      expected_chars.push_back(c);
   endfunction

   function automatic void push_hex_pair(input logic [7:0] value);
      push_char(hex_ascii(value[7:4]), 1'b0);
      push_char(hex_ascii(value[3:0]), 1'b0);
   endfunction

   // Builds the expected line for one frame and advances the line counter.
   function automatic void encode_line(input frame_type f);
      logic [SUM_WIDTH-1:0] sum;
      logic [7:0]           b;
      int                   sent;
      sum = mirror_checksum_start + SUM_WIDTH'(mirror_sequence);
      push_hex_pair(mirror_sequence);
      for (int i = 0; i < 4; i++) begin
         b = f.can_id[8*i +: 8];
         sum += SUM_WIDTH'(b);
         push_hex_pair(b);
      end
      sum += SUM_WIDTH'(f.data_length);
      push_hex_pair({4'd0, f.data_length});
      sent = (int'(f.data_length) > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(f.data_length);
      for (int i = 0; i < sent; i++) begin
         sum += SUM_WIDTH'(f.payload[i]);
         push_hex_pair(f.payload[i]);
      end
      sum += sum >> 16;
      sum += sum >> 16;
      sum += sum >> 8;
      sum += sum >> 8;
      push_hex_pair(sum[7:0]);
      push_char(mirror_terminator, 1'b1);
      mirror_sequence += 8'd1;
   endfunction

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         REG_CHECKSUM_START:  mirror_checksum_start = value;
         REG_LINE_TERMINATOR: mirror_terminator = value[CHAR_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_until_drained;
      do @(negedge clock);
      while (frames_pending.size() != 0 || req_if.valid || expected_chars.size() != 0);
   endtask

   task automatic queue_random_frames(input int count);
      frame_type f;
      @(negedge clock);
      repeat (count) begin
         f.can_id = $urandom;
         case ($urandom_range(9))
            0: f.can_id = '0;
            1: f.can_id = '1;
            default: ;
         endcase
         if ($urandom_range(4) == 0) begin
            f.data_length = 4'($urandom_range(15, 9));
         end else begin
            f.data_length = 4'($urandom_range(8));
         end
         for (int i = 0; i < MAX_PAYLOAD; i++) begin
            f.payload[i] = 8'($urandom);
         end
         frames_pending.push_back(f);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Sender: holds an item until it is taken, then maybe loads the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            encode_line(driven_frame);
         end
         if (!req_if.valid || req_if.ready) begin
            if (frames_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               staged_frame = frames_pending.pop_front();
               driven_frame          <= staged_frame;
               req_if.valid          <= 1'b1;
               req_if.can_id         <= staged_frame.can_id;
               req_if.data_length    <= staged_frame.data_length;
               req_if.payload_0      <= staged_frame.payload[0];
               req_if.payload_1      <= staged_frame.payload[1];
               req_if.payload_2      <= staged_frame.payload[2];
               req_if.payload_3      <= staged_frame.payload[3];
               req_if.payload_4      <= staged_frame.payload[4];
               req_if.payload_5      <= staged_frame.payload[5];
               req_if.payload_6      <= staged_frame.payload[6];
               req_if.payload_7      <= staged_frame.payload[7];
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each item against the oldest expected character.
   always @(posedge clock) begin
      line_char_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_chars.size() == 0) begin
               if (error_count < REPORT_LIMIT) begin
                  $display("unexpected item: char %h line_end %b",
                           rsp_if.ascii_char, rsp_if.line_end);
               end
               error_count++;
            end else begin
               want = expected_chars.pop_front();
               if (rsp_if.ascii_char !== want.ascii_char
                   || rsp_if.line_end !== want.line_end) begin
                  if (error_count < REPORT_LIMIT) begin
                     $display("char %h expected %h, line_end %b expected %b",
                              rsp_if.ascii_char, want.ascii_char,
                              rsp_if.line_end, want.line_end);
                  end
                  error_count++;
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      frame_type f;
      reset                 = 1'b1;
      csr_write_enable      = 1'b0;
      csr_index             = REG_CHECKSUM_START;
      csr_write_data        = '0;
      req_if.valid          = 1'b0;
      req_if.can_id         = '0;
      req_if.data_length    = '0;
      req_if.payload_0      = '0;
      req_if.payload_1      = '0;
      req_if.payload_2      = '0;
      req_if.payload_3      = '0;
      req_if.payload_4      = '0;
      req_if.payload_5      = '0;
      req_if.payload_6      = '0;
      req_if.payload_7      = '0;
      rsp_if.ready          = 1'b0;
      mirror_checksum_start = CHECKSUM_START_RESET;
      mirror_terminator     = LINE_TERMINATOR_RESET;
      mirror_sequence       = 8'd0;
      send_idle_pct         = 0;
      recv_stall_pct        = 0;
      error_count           = 0;
      cycle_count           = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed frames under the reset register values.
      @(negedge clock);
      f.can_id      = '0;
      f.data_length = '0;
      f.payload     = '0;
      frames_pending.push_back(f);
      f.can_id      = '1;
      f.data_length = 4'd8;
      f.payload     = '1;
      frames_pending.push_back(f);
      // Every DLC, including those above the payload limit; the bytes that are
      // not sent are still filled so that they would show if leaked.
      for (int d = 0; d < 16; d++) begin
         f.can_id      = $urandom;
         f.data_length = 4'(d);
         for (int i = 0; i < MAX_PAYLOAD; i++) begin
            f.payload[i] = 8'($urandom);
         end
         frames_pending.push_back(f);
      end
      wait_until_drained();

      write_register(REG_CHECKSUM_START, '0);
      write_register(REG_LINE_TERMINATOR, '0);
      queue_random_frames(PHASE_FRAMES);
      wait_until_drained();

      send_idle_pct = 57;
      write_register(REG_CHECKSUM_START, '1);
      write_register(REG_LINE_TERMINATOR, CSR_DATA_WIDTH'(8'hff));
      queue_random_frames(PHASE_FRAMES);
      wait_until_drained();

      // A terminator that looks like a hex digit must still close the line.
      send_idle_pct  = 0;
      recv_stall_pct = 57;
      write_register(REG_CHECKSUM_START, $urandom);
      write_register(REG_LINE_TERMINATOR, CSR_DATA_WIDTH'("A"));
      queue_random_frames(PHASE_FRAMES);
      wait_until_drained();

      send_idle_pct  = 36;
      recv_stall_pct = 36;
      write_register(REG_CHECKSUM_START, $urandom);
      write_register(REG_LINE_TERMINATOR, CSR_DATA_WIDTH'($urandom_range(255)));
      queue_random_frames(PHASE_FRAMES);
      wait_until_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_chars.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/cfah_pkg.sv
sv/cfah_req_if.sv
sv/cfah_rsp_if.sv
sv/cfah_ctrl.sv
sv/cfah_dp.sv
sv/can_frame_to_ascii_hex_line.sv
tb/tb_can_frame_to_ascii_hex_line.sv
